[hw/rtl/dhtis_pkg.sv]
`timescale 1ns / 1ps
package dhtis_pkg;

	localparam int TABLE_SIZE_DEF = 16;
	localparam int KEY_W = 31;
	localparam int IDX_W = 4;
	// Both key remainders come out of a three-stage reciprocal multiply pipeline.
	localparam int HASH_CYC = 3;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_INIT,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    load;
		logic    hash_run;
		logic    probe_init;
		logic    rd;
		logic    adv;
		logic    wr_ins;
		logic    clr_wr;
		logic    res_ld;
		logic    res_keep_idx;
		status_t res_status;
		logic    out_ld;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hash_done;
		logic slot_valid;
		logic key_match;
		logic is_search;
		logic probe_last;
		logic out_free;
	} sts_t;

endpackage

[hw/rtl/dhtis_ram.sv]
`timescale 1ns / 1ps
module dhtis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

[hw/rtl/dhtis_dp.sv]
`timescale 1ns / 1ps
module dhtis_dp
	import dhtis_pkg::*;
#(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic             req_type,
	input  logic [KEY_W-1:0] key,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [1:0]       status,
	output logic [IDX_W-1:0] slot_index
);

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int HCW = $clog2(HASH_CYC);
	localparam logic [AW:0] MOD1 = (AW + 1)'(TABLE_SIZE);
	localparam int L2 = $clog2(TABLE_SIZE - 1);
	localparam int RW = KEY_W + 2;
	localparam int PW = KEY_W + RW;
	localparam int SH1 = KEY_W + AW;
	localparam int SH2 = KEY_W + L2;
	// Rounded-up reciprocals; the rounding error stays below the divisor, which keeps
	// the quotient exact for every key.
	localparam logic [RW-1:0] RCP1 =
		RW'(((64'd1 << SH1) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
	localparam logic [RW-1:0] RCP2 =
		RW'(((64'd1 << SH2) + 64'(TABLE_SIZE - 1) - 64'd1) / 64'(TABLE_SIZE - 1));
	localparam logic [KEY_W-1:0] DIV1 = KEY_W'(TABLE_SIZE);
	localparam logic [KEY_W-1:0] DIV2 = KEY_W'(TABLE_SIZE - 1);

	logic [KEY_W-1:0] key_q;
	logic             search_q;
	logic [HCW-1:0]   hcnt_q;
	logic [PW-1:0]    prod1_q, prod2_q;
	logic [KEY_W-1:0] quo1, quo2, qd1_q, qd2_q, rem1, rem2;
	logic [AW-1:0]    r1_q, r2_q;
	logic [AW-1:0]    pos_q, step_q, cnt_q, clr_q;
	logic [AW:0]      pos_sum;
	logic [AW-1:0]    ram_addr;
	logic [KEY_W:0]   ram_rdata;
	status_t          res_status_q, rsp_status_q;
	logic [IDX_W-1:0] res_idx_q, rsp_idx_q;
	logic             rsp_valid_q;

	assign quo1 = KEY_W'(prod1_q >> SH1);
	assign quo2 = KEY_W'(prod2_q >> SH2);
	assign rem1 = key_q - qd1_q;
	assign rem2 = key_q - qd2_q;

	// Next probe position; both terms are below the table size.
	always_comb begin
		pos_sum = {1'b0, pos_q} + {1'b0, step_q};
		if (pos_sum >= MOD1) begin
			pos_sum = pos_sum - MOD1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key;
			search_q <= req_type;
		end
		// Multiply by the reciprocal, then form quotient times divisor, then subtract.
		if (cmd.hash_run) begin
			prod1_q <= {{RW{1'b0}}, key_q} * {{KEY_W{1'b0}}, RCP1};
			prod2_q <= {{RW{1'b0}}, key_q} * {{KEY_W{1'b0}}, RCP2};
			qd1_q <= quo1 * DIV1;
			qd2_q <= quo2 * DIV2;
			r1_q <= rem1[AW-1:0];
			r2_q <= rem2[AW-1:0];
		end
		if (cmd.probe_init) begin
			pos_q <= r1_q;
			step_q <= r2_q + AW'(1);
			cnt_q <= '0;
		end else if (cmd.adv) begin
			pos_q <= pos_sum[AW-1:0];
			cnt_q <= cnt_q + AW'(1);
		end
		if (cmd.res_ld) begin
			res_status_q <= cmd.res_status;
			res_idx_q <= cmd.res_keep_idx ? IDX_W'(pos_q) : '0;
		end
		if (cmd.out_ld) begin
			rsp_status_q <= res_status_q;
			rsp_idx_q <= res_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				hcnt_q <= '0;
			end else if (cmd.hash_run) begin
				hcnt_q <= hcnt_q + HCW'(1);
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.out_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign ram_addr = cmd.clr_wr ? clr_q : pos_q;

	// Each word holds the occupied mark above the key.
	dhtis_ram #(
		.WIDTH(KEY_W + 1),
		.DEPTH(TABLE_SIZE)
	) u_slots (
		.clk  (clk),
		.addr (ram_addr),
		.we   (cmd.clr_wr | cmd.wr_ins),
		.wdata(cmd.clr_wr ? '0 : {1'b1, key_q}),
		.re   (cmd.rd),
		.rdata(ram_rdata)
	);

	assign sts.clr_last = (clr_q == AW'(TABLE_SIZE - 1));
	assign sts.hash_done = (hcnt_q == HCW'(HASH_CYC - 1));
	assign sts.slot_valid = ram_rdata[KEY_W];
	assign sts.key_match = (ram_rdata[KEY_W-1:0] == key_q);
	assign sts.is_search = search_q;
	assign sts.probe_last = (cnt_q == AW'(TABLE_SIZE - 1));
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign status = rsp_status_q;
	assign slot_index = rsp_idx_q;

endmodule

[hw/rtl/dhtis_ctrl.sv]
`timescale 1ns / 1ps
module dhtis_ctrl
	import dhtis_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_run = 1'b1;
				if (sts.hash_done) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				cmd.probe_init = 1'b1;
				state_d = S_READ;
			end
			S_READ: begin
				cmd.rd = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!sts.slot_valid) begin
					cmd.res_ld = 1'b1;
					if (sts.is_search) begin
						cmd.res_status = ST_NOT_FOUND;
					end else begin
						cmd.res_status = ST_INSERTED;
						cmd.res_keep_idx = 1'b1;
						cmd.wr_ins = 1'b1;
					end
					state_d = S_DONE;
				end else if (sts.is_search && sts.key_match) begin
					cmd.res_ld = 1'b1;
					cmd.res_status = ST_FOUND;
					cmd.res_keep_idx = 1'b1;
					state_d = S_DONE;
				end else if (sts.probe_last) begin
					cmd.res_ld = 1'b1;
					cmd.res_status = sts.is_search ? ST_NOT_FOUND : ST_FULL;
					state_d = S_DONE;
				end else begin
					cmd.adv = 1'b1;
					state_d = S_READ;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/double_hash_table_insert_search.sv]
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// request   req_valid / req_stall  req_type, key
// response  rsp_valid / rsp_stall  status, slot_index
//
// The key of a transferred request is reduced in S_HASH, S_INIT sets up the probe, then
// each probe (1 to TABLE_SIZE of them) costs one slot RAM read and one compare. S_DONE
// loads the result into the output register once that is free, and the next request can
// be taken in the same cycle as the result becomes valid. After reset the slot RAM is
// cleared slot by slot before the first request transfer. A stalled response is held in
// the output register while the next request is already hashed and probed.
module double_hash_table_insert_search
	import dhtis_pkg::*;
#(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic             req_type,
	input  logic [KEY_W-1:0] key,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [1:0]       status,
	output logic [IDX_W-1:0] slot_index
);

	cmd_t cmd;
	sts_t sts;

	dhtis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dhtis_dp #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_type  (req_type),
		.key       (key),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.slot_index(slot_index)
	);

`ifndef ASSERT_OFF
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while the previous one is in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_ins |-> !sts.slot_valid)
		else $error("insert would overwrite an occupied slot");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> sts.out_free)
		else $error("result loaded over an untaken response");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == ST_NOT_FOUND || status == ST_FULL))
		|-> (slot_index == '0))
		else $error("slot index not zero on a miss");
`endif

endmodule
